[hdl/fss_pkg.sv]
// ----------------------------------------------------------------------------
// fss_pkg
// Shared constants and types of the frame synchronizer with checksum.
// ----------------------------------------------------------------------------
`default_nettype none

package fss_pkg;

    localparam int FRAME_BYTES  = 20;
    localparam int SUM_BYTES    = 18;
    localparam int HEADER_BYTES = 2;

    localparam int BYTE_W     = 8;
    localparam int INDEX_W    = 5;
    localparam int HEADER_W   = 16;
    localparam int SUM_W      = 16;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;
    localparam int FIFO_DEPTH = 2;

    localparam logic [CFG_ADDR_W-1:0] REG_HEADER_VALUE   = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_CHECKSUM_CHECK = 2'd1;

    typedef struct packed {
        logic [HEADER_W-1:0] header_value;
        logic                checksum_check;
    } cfg_t;

endpackage

`default_nettype wire

[hdl/fss_front.sv]
// ----------------------------------------------------------------------------
// fss_front
// Byte window, running checksum and frame match; pushes matched frames.
// ----------------------------------------------------------------------------
`default_nettype none

module fss_front #(
    parameter int FRAME_BYTES  = fss_pkg::FRAME_BYTES,
    parameter int SUM_BYTES    = fss_pkg::SUM_BYTES,
    parameter int HEADER_BYTES = fss_pkg::HEADER_BYTES
) (
    input  wire logic                                       clk,
    input  wire logic                                       rst_n,
    input  wire fss_pkg::cfg_t                              cfg,
    input  wire logic                                       push,
    input  wire logic [fss_pkg::BYTE_W-1:0]                 rx_byte,
    input  wire logic                                       fifo_full,
    output logic                                            full,
    output logic                                            frame_push,
    output logic [FRAME_BYTES-1:0][fss_pkg::BYTE_W-1:0]     frame_data
);

    localparam int SUM_EFF = (SUM_BYTES > FRAME_BYTES) ? FRAME_BYTES : SUM_BYTES;
    localparam int FILL_W  = $clog2(FRAME_BYTES + 1);
    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(FRAME_BYTES);

    logic [FRAME_BYTES-1:0][fss_pkg::BYTE_W-1:0] window_reg;
    logic [FRAME_BYTES-1:0][fss_pkg::BYTE_W-1:0] window_next;
    logic [fss_pkg::SUM_W-1:0]                   sum_reg;
    logic [fss_pkg::SUM_W-1:0]                   sum_next;
    logic [FILL_W-1:0]                           fill_reg;
    logic [FILL_W-1:0]                           fill_inc;
    logic [fss_pkg::BYTE_W-1:0]                  sum_in_byte;
    logic [fss_pkg::SUM_W-1:0]                   got_sum;
    logic                                        accept;
    logic                                        header_ok;
    logic                                        sum_ok;
    logic                                        match;

    generate
        if (SUM_EFF < FRAME_BYTES) begin : g_sum_inner
            assign sum_in_byte = window_reg[SUM_EFF];
        end
        else begin : g_sum_last
            assign sum_in_byte = rx_byte;
        end
    endgenerate

    assign accept      = push && !full;
    assign full        = fifo_full;
    assign window_next = {rx_byte, window_reg[FRAME_BYTES-1:1]};
    assign sum_next    = sum_reg - fss_pkg::SUM_W'(window_reg[0])
                                 + fss_pkg::SUM_W'(sum_in_byte);
    assign fill_inc    = (fill_reg < FILL_FULL) ? fill_reg + 1'b1 : fill_reg;
    assign got_sum     = {window_next[FRAME_BYTES-1], window_next[FRAME_BYTES-2]};

    always_comb
    begin
        if (HEADER_BYTES >= 2)
        begin
            header_ok = ({window_next[1], window_next[0]} == cfg.header_value);
        end
        else
        begin
            header_ok = (window_next[0] == cfg.header_value[fss_pkg::BYTE_W-1:0]);
        end
    end

    assign sum_ok     = !cfg.checksum_check || (got_sum == sum_next);
    assign match      = (fill_inc == FILL_FULL) && header_ok && sum_ok;
    assign frame_push = accept && match;
    assign frame_data = window_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= '0;
            sum_reg    <= '0;
            fill_reg   <= '0;
        end
        else if (accept)
        begin
            window_reg <= window_next;
            sum_reg    <= sum_next;
            fill_reg   <= match ? '0 : fill_inc;
        end
    end

endmodule

`default_nettype wire

[hdl/fss_frame_fifo.sv]
// ----------------------------------------------------------------------------
// fss_frame_fifo
// Short queue of whole frames between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

module fss_frame_fifo #(
    parameter int FRAME_BYTES = fss_pkg::FRAME_BYTES
) (
    input  wire logic                                       clk,
    input  wire logic                                       rst_n,
    input  wire logic                                       wr_en,
    input  wire logic [FRAME_BYTES-1:0][fss_pkg::BYTE_W-1:0] wr_data,
    input  wire logic                                       rd_en,
    output logic [FRAME_BYTES-1:0][fss_pkg::BYTE_W-1:0]     rd_data,
    output logic                                            fifo_full,
    output logic                                            fifo_empty
);

    localparam int PTR_W = $clog2(fss_pkg::FIFO_DEPTH);
    localparam int CNT_W = $clog2(fss_pkg::FIFO_DEPTH + 1);

    logic [FRAME_BYTES-1:0][fss_pkg::BYTE_W-1:0] mem [fss_pkg::FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign fifo_full  = (count_reg == CNT_W'(fss_pkg::FIFO_DEPTH));
    assign fifo_empty = (count_reg == '0);
    assign rd_data    = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (rd_en)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (wr_en && !rd_en)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (rd_en && !wr_en)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

[hdl/fss_back.sv]
// ----------------------------------------------------------------------------
// fss_back
// Serializer: loads a matched frame and hands it out one byte per item.
// ----------------------------------------------------------------------------
`default_nettype none

module fss_back #(
    parameter int FRAME_BYTES = fss_pkg::FRAME_BYTES
) (
    input  wire logic                                        clk,
    input  wire logic                                        rst_n,
    input  wire logic [FRAME_BYTES-1:0][fss_pkg::BYTE_W-1:0] rd_data,
    input  wire logic                                        fifo_empty,
    output logic                                             rd_en,
    input  wire logic                                        pop,
    output logic                                             empty,
    output logic [fss_pkg::BYTE_W-1:0]                       frame_byte,
    output logic [fss_pkg::INDEX_W-1:0]                      byte_index,
    output logic                                             last
);

    localparam int IDX_W = $clog2(FRAME_BYTES);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(FRAME_BYTES - 1);

    logic [FRAME_BYTES-1:0][fss_pkg::BYTE_W-1:0] frame_reg;
    logic [IDX_W-1:0]                            idx_reg;
    logic                                        busy_reg;
    logic                                        take;

    assign empty      = !busy_reg;
    assign frame_byte = frame_reg[0];
    assign byte_index = fss_pkg::INDEX_W'(idx_reg);
    assign last       = (idx_reg == IDX_LAST);
    assign take       = pop && busy_reg;
    assign rd_en      = !fifo_empty && (!busy_reg || (take && last));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else if (rd_en)
        begin
            busy_reg <= 1'b1;
            idx_reg  <= '0;
        end
        else if (take)
        begin
            busy_reg <= !last;
            idx_reg  <= last ? '0 : idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            frame_reg <= rd_data;
        end
        else if (take)
        begin
            frame_reg <= {fss_pkg::BYTE_W'(0), frame_reg[FRAME_BYTES-1:1]};
        end
    end

endmodule

`default_nettype wire

[hdl/frame_sync_sum_check_core.sv]
// ----------------------------------------------------------------------------
// frame_sync_sum_check_core
// Fixed-length frame synchronizer with header match and additive checksum.
// ----------------------------------------------------------------------------
// Usage:
//   Input queue side: drive rx_byte and push; the byte is taken when push is
//   high and full is low. One byte per cycle is taken while full is low.
//   Output queue side: while empty is low, frame_byte, byte_index and last
//   show the oldest waiting frame byte; it is taken when pop is high.
//   Configuration: cfg_valid/cfg_ready write cfg_data to register cfg_index
//   (0 header_value, 1 checksum_check); cfg_ready is always high.
//   Output path: with the serializer idle, the edge that takes the completing
//   byte writes a matched frame into the frame queue; the serializer then loads
//   it and shows its first byte on the output; the frame then drains at one
//   byte per cycle while pop stays high.
//   Throughput: 1 byte per cycle in while full is low. A new match needs
//   FRAME_BYTES more bytes, as many as the serializer hands out per frame.
//   The frame queue holds 2 frames; full rises only when it and the
//   serializer are all occupied, i.e. when the receiver stalls on pop.
//   Reset: window, checksum and byte count clear, the queue empties,
//   header_value clears and checksum_check sets.
// ----------------------------------------------------------------------------
`default_nettype none

module frame_sync_sum_check_core #(
    parameter int FRAME_BYTES  = fss_pkg::FRAME_BYTES,
    parameter int SUM_BYTES    = fss_pkg::SUM_BYTES,
    parameter int HEADER_BYTES = fss_pkg::HEADER_BYTES
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              push,
    output logic                                   full,
    input  wire logic [fss_pkg::BYTE_W-1:0]        rx_byte,
    output logic                                   empty,
    input  wire logic                              pop,
    output logic [fss_pkg::BYTE_W-1:0]             frame_byte,
    output logic [fss_pkg::INDEX_W-1:0]            byte_index,
    output logic                                   last,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [fss_pkg::CFG_ADDR_W-1:0]    cfg_index,
    input  wire logic [fss_pkg::CFG_DATA_W-1:0]    cfg_data
);

    fss_pkg::cfg_t cfg_reg;

    logic                                        fifo_full;
    logic                                        fifo_empty;
    logic                                        frame_push;
    logic                                        rd_en;
    logic [FRAME_BYTES-1:0][fss_pkg::BYTE_W-1:0] frame_data;
    logic [FRAME_BYTES-1:0][fss_pkg::BYTE_W-1:0] rd_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.header_value   <= '0;
            cfg_reg.checksum_check <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                fss_pkg::REG_HEADER_VALUE:
                begin
                    cfg_reg.header_value <= cfg_data[fss_pkg::HEADER_W-1:0];
                end
                fss_pkg::REG_CHECKSUM_CHECK:
                begin
                    cfg_reg.checksum_check <= cfg_data[0];
                end
                default:
                begin
                    cfg_reg <= cfg_reg;
                end
            endcase
        end
    end

    fss_front #(
        .FRAME_BYTES  (FRAME_BYTES),
        .SUM_BYTES    (SUM_BYTES),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .push       (push),
        .rx_byte    (rx_byte),
        .fifo_full  (fifo_full),
        .full       (full),
        .frame_push (frame_push),
        .frame_data (frame_data)
    );

    fss_frame_fifo #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr_en      (frame_push),
        .wr_data    (frame_data),
        .rd_en      (rd_en),
        .rd_data    (rd_data),
        .fifo_full  (fifo_full),
        .fifo_empty (fifo_empty)
    );

    fss_back #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .rd_data    (rd_data),
        .fifo_empty (fifo_empty),
        .rd_en      (rd_en),
        .pop        (pop),
        .empty      (empty),
        .frame_byte (frame_byte),
        .byte_index (byte_index),
        .last       (last)
    );

endmodule

`default_nettype wire

[hdl/fss_checker.sv]
// ----------------------------------------------------------------------------
// fss_checker
// Port-level checks of frame ordering and output holding.
// ----------------------------------------------------------------------------
`default_nettype none

module fss_checker #(
    parameter int FRAME_BYTES = fss_pkg::FRAME_BYTES
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              empty,
    input  wire logic                              pop,
    input  wire logic [fss_pkg::BYTE_W-1:0]        frame_byte,
    input  wire logic [fss_pkg::INDEX_W-1:0]       byte_index,
    input  wire logic                              last
);

    localparam logic [fss_pkg::INDEX_W-1:0] IDX_LAST =
        fss_pkg::INDEX_W'(FRAME_BYTES - 1);

    a_last_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (last == (byte_index == IDX_LAST)))
        else $error("last flag does not match final byte index");

    a_index_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !empty && !last) |=>
            (!empty && byte_index == $past(byte_index) + 1'b1))
        else $error("frame byte index did not advance by one");

    a_new_frame_start: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !empty && last) |=> (empty || byte_index == '0))
        else $error("next frame did not start at index zero");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(frame_byte) && $stable(byte_index)))
        else $error("output item changed while stalled");

endmodule

bind frame_sync_sum_check_core fss_checker #(
    .FRAME_BYTES (FRAME_BYTES)
) u_fss_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .empty      (empty),
    .pop        (pop),
    .frame_byte (frame_byte),
    .byte_index (byte_index),
    .last       (last)
);

`default_nettype wire
